### rtl/ccb_pkg.sv
// shared types, constants and register codes for the clipped color-key blitter
`timescale 1ns / 1ps
package ccb_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int PIXEL_BITS  = 32;
  localparam int DIM_W       = 13;
  localparam int KEY_W       = 24;
  localparam int ADDR_W      = 24;
  localparam int BASE_W      = 25;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd6;

  localparam logic [DIM_W-1:0] DEST_WIDTH_RST    = 13'd640;
  localparam logic [DIM_W-1:0] DEST_HEIGHT_RST   = 13'd480;
  localparam logic [DIM_W-1:0] POS_RST           = 13'd0;
  localparam logic [DIM_W-1:0] SPRITE_DIM_RST    = 13'd1;
  localparam logic [KEY_W-1:0] KEY_COLOR_RST     = 24'h000000;

  typedef struct packed {
    logic [DIM_W-1:0] dest_width;
    logic [DIM_W-1:0] dest_height;
    logic [DIM_W-1:0] pos_x;
    logic [DIM_W-1:0] pos_y;
    logic [DIM_W-1:0] sprite_width;
    logic [DIM_W-1:0] sprite_height;
    logic [KEY_W-1:0] key_color;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  start_req;
  } pix_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     write_addr;
    logic [PIXEL_BITS-1:0] write_data;
  } wr_beat_t;

  typedef struct packed {
    logic [DIM_W-1:0]      x;
    logic [DIM_W-1:0]      y;
    logic [PIXEL_BITS-1:0] pixel;
  } job_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
    logic              push;
    logic              pop;
  } q_stat_t;

endpackage

### rtl/ccb_stream_if.sv
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps
interface ccb_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/ccb_front.sv
// front end: sprite counters, clipping and color-key test
`timescale 1ns / 1ps
module ccb_front #(
  parameter int MAX_DIM = ccb_pkg::MAX_DIM_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  ccb_stream_if.sink    in_pix,
  input  ccb_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          push,
  output ccb_pkg::job_t push_job
);
  import ccb_pkg::*;

  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
  localparam int XW = SW + 1;

  logic [CW-1:0]        col_r, col_nxt, row_r, row_nxt;
  logic [CW-1:0]        col_use, row_use;
  logic [SW-1:0]        eff_w, eff_h, col_inc, row_inc;
  logic signed [XW-1:0] x, y;
  logic                 acc, in_frame, opaque;

  assign in_pix.ready = !q_full;
  assign acc          = in_pix.valid && in_pix.ready;

  // sprite size clamped to 1..MAX_DIM
  always_comb begin
    if (cfg.sprite_width == '0) begin
      eff_w = SW'(1);
    end else if (SW'(cfg.sprite_width) > SW'(MAX_DIM)) begin
      eff_w = SW'(MAX_DIM);
    end else begin
      eff_w = SW'(cfg.sprite_width);
    end
    if (cfg.sprite_height == '0) begin
      eff_h = SW'(1);
    end else if (SW'(cfg.sprite_height) > SW'(MAX_DIM)) begin
      eff_h = SW'(MAX_DIM);
    end else begin
      eff_h = SW'(cfg.sprite_height);
    end
  end

  always_comb begin
    col_use = (in_pix.data.start_req || SW'(col_r) >= eff_w) ? '0 : col_r;
    row_use = (in_pix.data.start_req || SW'(row_r) >= eff_h) ? '0 : row_r;
    x = XW'(signed'(cfg.pos_x)) + signed'(XW'(col_use));
    y = XW'(signed'(cfg.pos_y)) + signed'(XW'(row_use));
    in_frame = !x[XW-1] && (x[SW-1:0] < SW'(cfg.dest_width))
            && !y[XW-1] && (y[SW-1:0] < SW'(cfg.dest_height));
    opaque = in_pix.data.pixel[KEY_W-1:0] != cfg.key_color;
  end

  always_comb begin
    col_inc = SW'(col_use) + SW'(1);
    row_inc = SW'(row_use) + SW'(1);
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= eff_h) ? '0 : row_inc[CW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_use;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign push           = acc && in_frame && opaque;
  assign push_job.x     = x[DIM_W-1:0];
  assign push_job.y     = y[DIM_W-1:0];
  assign push_job.pixel = in_pix.data.pixel;

endmodule

### rtl/ccb_queue.sv
// small job queue between front and back end
`timescale 1ns / 1ps
module ccb_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ccb_pkg::job_t    push_job,
  input  logic             pop_ready,
  output logic             pop_valid,
  output ccb_pkg::job_t    pop_job,
  output ccb_pkg::q_stat_t stat
);
  import ccb_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              pop;

  assign pop_valid = count_r != '0;
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign stat.count = count_r;
  assign stat.full  = count_r == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = !pop_valid;
  assign stat.push  = push;
  assign stat.pop   = pop;

endmodule

### rtl/ccb_back.sv
// back end: row base multiply, address add and output register
`timescale 1ns / 1ps
module ccb_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [12:0]    dest_width,
  input  logic           job_valid,
  input  ccb_pkg::job_t  job,
  output logic           job_ready,
  ccb_stream_if.source   out_wr
);
  import ccb_pkg::*;

  logic                  a_v_r;
  logic [BASE_W-1:0]     base_r;
  logic [DIM_W-1:0]      ax_r;
  logic [PIXEL_BITS-1:0] apix_r;
  logic [2*DIM_W-1:0]    prod;
  logic [BASE_W-1:0]     addr_sum;
  logic                  o_v_r;
  wr_beat_t              o_beat_r;
  logic                  b_ready;

  assign b_ready   = !o_v_r || out_wr.ready;
  assign job_ready = !a_v_r || b_ready;
  assign prod      = job.y * dest_width;
  assign addr_sum  = base_r + BASE_W'(ax_r);

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (job_ready) begin
      a_v_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready) begin
      base_r <= prod[BASE_W-1:0];
      ax_r   <= job.x;
      apix_r <= job.pixel;
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (b_ready) begin
      o_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      o_beat_r.write_addr <= addr_sum[ADDR_W-1:0];
      o_beat_r.write_data <= apix_r;
    end
  end

  assign out_wr.valid = o_v_r;
  assign out_wr.data  = o_beat_r;

endmodule

### rtl/clipped_color_key_blitter.sv
// top level of the clipped color-key sprite blitter
//
// in_pix takes one sprite pixel per beat in raster order; start_req on a beat
// marks the first pixel of a sprite and restarts the column and row counters.
// out_wr gives one framebuffer write per pixel that lands inside the
// destination and whose low 24 bits differ from the key color: write_addr is
// row times dest_width plus column, write_data the pixel unchanged.
// cfg_we, cfg_idx and cfg_wdata write the seven registers; write them only
// while no pixel is in flight. A register change takes effect from the next
// pixel.
// Throughput is one pixel per cycle while the job queue is not full. An
// accepted pixel beat is written to the queue at the accepting edge, then
// passes the multiply stage and the output register before out_wr.valid rises.
// The single 13x13 row-base multiplier feeds the multiply stage.
// Transparent and clipped pixels are dropped at the front and never reach the
// back end.
// Reset empties the pipeline, clears the counters and loads the register
// defaults. When out_wr stalls, a four-entry queue keeps taking pixels until
// it fills, then in_pix.ready drops.
`timescale 1ns / 1ps
module clipped_color_key_blitter #(
  parameter int MAX_DIM = ccb_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  ccb_stream_if.sink                       in_pix,
  ccb_stream_if.source                     out_wr,
  input  logic                             cfg_we,
  input  logic [ccb_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ccb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ccb_pkg::*;

  cfg_t    cfg_r;
  logic    push;
  job_t    push_job;
  logic    pop_valid, pop_ready;
  job_t    pop_job;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width    <= DEST_WIDTH_RST;
      cfg_r.dest_height   <= DEST_HEIGHT_RST;
      cfg_r.pos_x         <= POS_RST;
      cfg_r.pos_y         <= POS_RST;
      cfg_r.sprite_width  <= SPRITE_DIM_RST;
      cfg_r.sprite_height <= SPRITE_DIM_RST;
      cfg_r.key_color     <= KEY_COLOR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEST_WIDTH: begin
          cfg_r.dest_width <= cfg_wdata[DIM_W-1:0];
        end
        REG_DEST_HEIGHT: begin
          cfg_r.dest_height <= cfg_wdata[DIM_W-1:0];
        end
        REG_POS_X: begin
          cfg_r.pos_x <= cfg_wdata[DIM_W-1:0];
        end
        REG_POS_Y: begin
          cfg_r.pos_y <= cfg_wdata[DIM_W-1:0];
        end
        REG_SPRITE_WIDTH: begin
          cfg_r.sprite_width <= cfg_wdata[DIM_W-1:0];
        end
        REG_SPRITE_HEIGHT: begin
          cfg_r.sprite_height <= cfg_wdata[DIM_W-1:0];
        end
        REG_KEY_COLOR: begin
          cfg_r.key_color <= cfg_wdata[KEY_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  ccb_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .cfg      (cfg_r),
    .q_full   (q_stat.full),
    .push     (push),
    .push_job (push_job)
  );

  ccb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop_ready (pop_ready),
    .pop_valid (pop_valid),
    .pop_job   (pop_job),
    .stat      (q_stat)
  );

  ccb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dest_width (cfg_r.dest_width),
    .job_valid  (pop_valid),
    .job        (pop_job),
    .job_ready  (pop_ready),
    .out_wr     (out_wr)
  );

`ifndef NO_ASSERTIONS
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_pix.ready)
    else $error("pixel beat taken while job queue full");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("job queue count out of range");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((QCNT_W + 1)'(q_stat.count) ==
      (QCNT_W + 1)'($past(q_stat.count)) + (QCNT_W + 1)'($past(q_stat.push))
      - (QCNT_W + 1)'($past(q_stat.pop))))
    else $error("job queue count does not match push and pop");

  a_push_only_when_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.push |-> (in_pix.valid && in_pix.ready))
    else $error("job pushed without an accepted pixel beat");
`endif

endmodule
